// ===== rtl/coh_pkg.sv =====
// coh_pkg: shared constants, codes and transfer types for the one-hot encoder
// used by coh_distinct_table and categorical_one_hot_encoder_unit; no dependencies
`default_nettype none

package coh_pkg;

	localparam int MAX_ROWS  = 1024;
	localparam int MAX_CATS  = 64;
	localparam int CODE_W    = 32;
	localparam int ROW_AW    = $clog2(MAX_ROWS);
	localparam int ROW_CW    = $clog2(MAX_ROWS + 1);
	localparam int CAT_AW    = $clog2(MAX_CATS);
	localparam int CAT_CW    = $clog2(MAX_CATS + 1);
	localparam int OH_W      = 64;
	localparam int IDX_W     = 6;
	localparam int GRP_W     = 8;
	localparam int NUM_GRP   = (MAX_CATS + GRP_W - 1) / GRP_W;
	localparam int GRP_CW    = $clog2(GRP_W + 1);
	localparam int IN_DATA_W = 48;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_TABLE_FULL = 2'd1,
		ERR_ROWS_FULL  = 2'd2,
		ERR_NO_ROW     = 2'd3
	} err_t;

	// write port of the distinct code table
	typedef struct packed {
		logic              en;
		logic [CAT_AW-1:0] addr;
		logic [CODE_W-1:0] data;
	} tbl_wr_t;

	// status of one transaction carried down the pipe
	typedef struct packed {
		logic [CAT_CW-1:0] cat_count;
		logic [ROW_CW-1:0] rows;
		err_t              err;
		logic              rd_ok;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/coh_distinct_table.sv =====
// coh_distinct_table: register table of distinct category codes with parallel
// equality probe for loads and less-than compare vector for rank queries; uses coh_pkg
`default_nettype none

module coh_distinct_table
	import coh_pkg::*;
(
	input  wire logic                clk,
	input  wire tbl_wr_t             wr,
	input  wire logic [CAT_CW-1:0]   cnt,
	input  wire logic [CODE_W-1:0]   probe_code,
	output logic                     known,
	input  wire logic [CAT_CW-1:0]   rank_cnt,
	input  wire logic [CODE_W-1:0]   rank_code,
	output logic [MAX_CATS-1:0]      lt_vec
);

	logic [CODE_W-1:0]   tbl_q [MAX_CATS];
	logic [MAX_CATS-1:0] hit;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			tbl_q[wr.addr] <= wr.data;
		end
	end

	for (genvar k = 0; k < MAX_CATS; k++) begin : g_cmp
		localparam logic [CAT_CW-1:0] KIDX = CAT_CW'(k);
		assign hit[k]    = (KIDX < cnt) && (tbl_q[k] == probe_code);
		assign lt_vec[k] = (KIDX < rank_cnt) && (tbl_q[k] < rank_code);
	end

	assign known = |hit;

endmodule

`default_nettype wire

// ===== rtl/categorical_one_hot_encoder_unit.sv =====
// categorical_one_hot_encoder_unit: load/read/clear one-hot encoder top level
// depends on coh_pkg and coh_distinct_table
//
//  channel | dir | tdata fields (low bit up)                               | tuser
//  s_*     | in  | code[31:0], row_index[41:32], zero pad to 48            | command
//  m_*     | out | one_hot[63:0], category_index[69:64],                   | error
//          |     | category_count[76:70], rows_loaded[87:77]               |
//
// one transaction per cycle sustained while the m side does not stall
// stages: s1 input reg, command executes at end of s1 (row store write/read issue),
// s2 distinct table compare, s3 group bit counts, s4 rank sum, then output register
// a stalled m side freezes every stage and s_tready drops; no cycle is lost otherwise
// arst_n clears counts and valids; stores need no clearing since counts bound all reads
`default_nettype none

module categorical_one_hot_encoder_unit
	import coh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // code, row_index
	input  wire logic [1:0]            s_tuser,  // command
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // one_hot, category_index, category_count, rows_loaded
	output logic [1:0]                 m_tuser   // error
);

	function automatic logic [GRP_CW-1:0] popcnt_grp(input logic [GRP_W-1:0] v);
		logic [GRP_CW-1:0] s;
		s = '0;
		for (int i = 0; i < GRP_W; i++) begin
			s = s + GRP_CW'(v[i]);
		end
		return s;
	endfunction

	logic en;

	// stage 1: input register
	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [CODE_W-1:0] code_s1;
	logic [ROW_AW-1:0] row_idx_s1;

	// stage 2
	logic              vld_s2;
	res_t              res_s2;
	logic [CAT_CW-1:0] cnt_s2;
	logic [CODE_W-1:0] rd_data_s2;

	// stage 3
	logic                vld_s3;
	res_t                res_s3;
	logic [MAX_CATS-1:0] lt_s3;

	// stage 4
	logic              vld_s4;
	res_t              res_s4;
	logic [GRP_CW-1:0] grp_s4 [NUM_GRP];

	// output register
	logic [OH_W-1:0]  one_hot_q;
	logic [IDX_W-1:0] cat_idx_q;
	res_t             res_q;

	logic [CAT_CW-1:0] cat_cnt_q;
	logic [ROW_CW-1:0] row_cnt_q;

	logic [CODE_W-1:0] row_mem [MAX_ROWS];

	// command execution
	logic                known;
	logic [MAX_CATS-1:0] lt_vec;
	tbl_wr_t             tbl_wr;
	logic                mem_we;
	res_t                res_nxt;
	logic [CAT_CW-1:0]   cat_cnt_nxt;
	logic [ROW_CW-1:0]   row_cnt_nxt;
	logic                exec;
	logic                row_full;
	logic                cat_full;

	logic [CAT_CW-1:0] rank;
	logic [MAX_CATS+GRP_W*NUM_GRP-MAX_CATS-1:0] lt_pad;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign exec     = en && vld_s1;
	assign row_full = (row_cnt_q >= ROW_CW'(MAX_ROWS));
	assign cat_full = (cat_cnt_q >= CAT_CW'(MAX_CATS));

	coh_distinct_table u_tbl (
		.clk        (clk),
		.wr         (tbl_wr),
		.cnt        (cat_cnt_q),
		.probe_code (code_s1),
		.known      (known),
		.rank_cnt   (cnt_s2),
		.rank_code  (rd_data_s2),
		.lt_vec     (lt_vec)
	);

	always_comb begin
		tbl_wr      = '{en: 1'b0, addr: cat_cnt_q[CAT_AW-1:0], data: code_s1};
		mem_we      = 1'b0;
		cat_cnt_nxt = cat_cnt_q;
		row_cnt_nxt = row_cnt_q;
		res_nxt.err   = ERR_OK;
		res_nxt.rd_ok = 1'b0;
		unique case (cmd_s1)
			CMD_LOAD: begin
				if (row_full) begin
					res_nxt.err = ERR_ROWS_FULL;
				end else if (!known && cat_full) begin
					res_nxt.err = ERR_TABLE_FULL;
				end else begin
					mem_we      = exec;
					row_cnt_nxt = row_cnt_q + ROW_CW'(1);
					if (!known) begin
						tbl_wr.en   = exec;
						cat_cnt_nxt = cat_cnt_q + CAT_CW'(1);
					end
				end
			end
			CMD_READ: begin
				if ({1'b0, row_idx_s1} >= row_cnt_q) begin
					res_nxt.err = ERR_NO_ROW;
				end else begin
					res_nxt.rd_ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				cat_cnt_nxt = '0;
				row_cnt_nxt = '0;
			end
			default: begin
			end
		endcase
		res_nxt.cat_count = cat_cnt_nxt;
		res_nxt.rows      = row_cnt_nxt;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			m_tvalid  <= 1'b0;
			cat_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (en) begin
			vld_s1   <= s_tvalid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			m_tvalid <= vld_s4;
			if (vld_s1) begin
				cat_cnt_q <= cat_cnt_nxt;
				row_cnt_q <= row_cnt_nxt;
			end
		end
	end

	// row store: one write port at the fill point, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[row_cnt_q[ROW_AW-1:0]] <= code_s1;
		end
		if (en) begin
			rd_data_s2 <= row_mem[row_idx_s1];
		end
	end

	assign lt_pad = '0;

	always_comb begin
		rank = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			rank = rank + CAT_CW'(grp_s4[g]);
		end
	end

	// payload pipe
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1     <= cmd_t'(s_tuser);
			code_s1    <= s_tdata[CODE_W-1:0];
			row_idx_s1 <= s_tdata[CODE_W +: ROW_AW];

			res_s2 <= res_nxt;
			cnt_s2 <= cat_cnt_q;

			res_s3 <= res_s2;
			lt_s3  <= lt_vec;

			res_s4 <= res_s3;
			for (int g = 0; g < NUM_GRP; g++) begin
				grp_s4[g] <= popcnt_grp(GRP_W'({lt_pad, lt_s3} >> (g * GRP_W)));
			end

			res_q <= res_s4;
			if (res_s4.rd_ok) begin
				one_hot_q <= {{(OH_W-1){1'b0}}, 1'b1} << rank[CAT_AW-1:0];
				cat_idx_q <= IDX_W'(rank);
			end else begin
				one_hot_q <= '0;
				cat_idx_q <= '0;
			end
		end
	end

	assign m_tdata = {res_q.rows, res_q.cat_count, cat_idx_q, one_hot_q};
	assign m_tuser = res_q.err;

	a_cat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cat_cnt_q <= CAT_CW'(MAX_CATS))
		else $error("distinct count beyond table size");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= ROW_CW'(MAX_ROWS))
		else $error("row count beyond store size");

	a_cat_le_rows: assert property (@(posedge clk) disable iff (!arst_n)
		{{(ROW_CW){1'b0}}, cat_cnt_q} <= {{(CAT_CW){1'b0}}, row_cnt_q})
		else $error("more distinct codes than loaded rows");

	a_err_no_hot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_q.err != ERR_OK) |-> (one_hot_q == '0) && (cat_idx_q == '0))
		else $error("one-hot set on a failed transaction");

	a_hot_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.rd_ok |-> $onehot(one_hot_q))
		else $error("read result is not one-hot");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for categorical_one_hot_encoder_unit, load/read/clear traffic
// holds its own model of the row store and the distinct code table; depends on coh_pkg
`timescale 1ns / 100ps

module tb_top;
	import coh_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 32;

	typedef struct packed {
		cmd_t        cmd;
		logic [9:0]  row;
		logic [31:0] code;
	} command_t;

	typedef struct packed {
		logic [63:0] one_hot;
		logic [5:0]  rank;
		logic [6:0]  n_cats;
		logic [10:0] n_rows;
		err_t        err;
	} encoding_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = CMD_NOP;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	command_t  pending_q[$];
	encoding_t encodings_q[$];
	command_t  in_flight;
	command_t  next_cmd;
	encoding_t got;
	encoding_t want;
	int        send_pct = 0;
	int        recv_pct = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;

	// model state
	logic [31:0] row_codes[MAX_ROWS];
	logic [31:0] seen_codes[MAX_CATS];
	int unsigned n_seen = 0;
	int unsigned n_rows = 0;

	categorical_one_hot_encoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// executes one command on the model and returns the encoding it yields
	function automatic encoding_t encode_command(input command_t c);
		encoding_t   e;
		logic        known;
		int unsigned rank;
		logic [31:0] v;
		e = '0;
		e.err = ERR_OK;
		case (c.cmd)
			CMD_LOAD: begin
				if (n_rows >= MAX_ROWS) begin
					e.err = ERR_ROWS_FULL;
				end else begin
					known = 1'b0;
					for (int k = 0; k < n_seen; k++)
						if (seen_codes[k] == c.code) known = 1'b1;
					if (!known && n_seen >= MAX_CATS) begin
						e.err = ERR_TABLE_FULL;
					end else begin
						if (!known) begin
							seen_codes[n_seen] = c.code;
							n_seen++;
						end
						row_codes[n_rows] = c.code;
						n_rows++;
					end
				end
			end
			CMD_READ: begin
				if (c.row >= n_rows) begin
					e.err = ERR_NO_ROW;
				end else begin
					v = row_codes[c.row];
					rank = 0;
					for (int k = 0; k < n_seen; k++)
						if (seen_codes[k] < v) rank++;
					e.rank = rank[5:0];
					e.one_hot = 64'd1 << rank;
				end
			end
			CMD_CLEAR: begin
				n_seen = 0;
				n_rows = 0;
			end
			default: ;
		endcase
		e.n_cats = n_seen[6:0];
		e.n_rows = n_rows[10:0];
		return e;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_NOP;
		end else begin
			if (s_tvalid && s_tready)
				encodings_q.push_back(encode_command(in_flight));
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_pct) begin
					next_cmd = pending_q.pop_front();
					in_flight <= next_cmd;
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, next_cmd.row, next_cmd.code};
					s_tuser <= next_cmd.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.one_hot = m_tdata[63:0];
			got.rank = m_tdata[69:64];
			got.n_cats = m_tdata[76:70];
			got.n_rows = m_tdata[87:77];
			got.err = err_t'(m_tuser);
			if (encodings_q.size() == 0) begin
				$display("%0t: unexpected transaction, actual %h", $time, got);
				mismatches++;
			end else begin
				want = encodings_q.pop_front();
				if (got.one_hot !== want.one_hot) begin
					$display("%0t: one_hot expected %h actual %h", $time, want.one_hot,
						got.one_hot);
					mismatches++;
				end
				if (got.rank !== want.rank) begin
					$display("%0t: category_index expected %0d actual %0d", $time, want.rank,
						got.rank);
					mismatches++;
				end
				if (got.n_cats !== want.n_cats) begin
					$display("%0t: category_count expected %0d actual %0d", $time,
						want.n_cats, got.n_cats);
					mismatches++;
				end
				if (got.n_rows !== want.n_rows) begin
					$display("%0t: rows_loaded expected %0d actual %0d", $time, want.n_rows,
						got.n_rows);
					mismatches++;
				end
				if (got.err !== want.err) begin
					$display("%0t: error expected %0d actual %0d", $time, want.err, got.err);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send(input cmd_t cmd, input logic [31:0] code, input logic [9:0] row);
		command_t c;
		c.cmd = cmd;
		c.code = code;
		c.row = row;
		pending_q.push_back(c);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || encodings_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_code();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(7))
			0: v = 32'h0;
			1: v = 32'hFFFF_FFFF;
			default: ;
		endcase
		return v;
	endfunction

	// clear, load from a small pool of codes with occasional reads, then query rows with some late loads and nops mixed in
	task automatic load_and_query(input int n_loads, input int n_codes, input int n_reads);
		logic [31:0] pool[$];
		int          r;
		for (int i = 0; i < n_codes; i++) pool.push_back(pick_code());
		send(CMD_CLEAR, $urandom, 10'($urandom));
		for (int i = 0; i < n_loads; i++) begin
			send(CMD_LOAD, pool[$urandom_range(n_codes - 1)], 10'($urandom));
			if ($urandom_range(11) == 0)
				send(CMD_READ, $urandom, 10'($urandom_range(i)));
		end
		for (int i = 0; i < n_reads; i++) begin
			r = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(n_loads - 1);
			send(CMD_READ, $urandom, r[9:0]);
			case ($urandom_range(19))
				0, 1: send(CMD_LOAD, pick_code(), 10'($urandom));
				2: send(CMD_NOP, $urandom, 10'($urandom));
				default: ;
			endcase
		end
	endtask

	task automatic noise(input int n);
		for (int i = 0; i < n; i++)
			send(cmd_t'($urandom_range(3)), pick_code(), 10'($urandom));
	endtask

	initial begin
		logic [31:0] distinct[$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, nop, clear
		send(CMD_READ, 32'h0, 10'd0);
		send(CMD_NOP, 32'hFFFF_FFFF, 10'h3FF);
		send(CMD_LOAD, 32'h0, 10'h3FF);
		send(CMD_LOAD, 32'hFFFF_FFFF, 10'd0);
		send(CMD_LOAD, 32'h8000_0000, 10'd0);
		send(CMD_LOAD, 32'hFFFF_FFFF, 10'd0);
		for (int i = 0; i < 4; i++) send(CMD_READ, 32'hFFFF_FFFF, i[9:0]);
		send(CMD_READ, 32'h0, 10'd4);
		send(CMD_READ, 32'h0, 10'h3FF);
		send(CMD_CLEAR, 32'h0, 10'd0);
		send(CMD_READ, 32'h0, 10'd0);
		send(CMD_LOAD, 32'd5, 10'd0);
		send(CMD_LOAD, 32'd3, 10'd0);
		send(CMD_LOAD, 32'd7, 10'd0);
		for (int i = 0; i < 3; i++) send(CMD_READ, 32'h0, i[9:0]);
		drain();

		// fill the distinct table, overflow it, then read every rank
		send(CMD_CLEAR, $urandom, 10'($urandom));
		for (int k = 0; k < MAX_CATS; k++) begin
			distinct.push_back(($urandom & 32'hFFFF_FFC0) | k);
			send(CMD_LOAD, distinct[k], 10'($urandom));
		end
		send(CMD_LOAD, 32'hFFFF_FFFF, 10'($urandom));
		send(CMD_LOAD, distinct[5], 10'($urandom));
		for (int k = 0; k <= MAX_CATS; k++) send(CMD_READ, $urandom, k[9:0]);
		drain();

		// random traffic under each backpressure setting
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_pct = 0; recv_pct = 0; end
				1: begin send_pct = 65; recv_pct = 0; end
				2: begin send_pct = 0; recv_pct = 65; end
				default: begin send_pct = 6; recv_pct = 6; end
			endcase
			repeat (3)
				load_and_query($urandom_range(40, 1), $urandom_range(50, 1),
					$urandom_range(20, 5));
			noise(10);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
